// ===== design/slot_free_list_table_assert.svh =====
// Assertion macros used by the slot free list table top level.
`ifndef SLOT_FREE_LIST_TABLE_ASSERT_SVH
`define SLOT_FREE_LIST_TABLE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SFLT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SFLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sflt_pkg.sv =====
// Types and codes shared by the slot free list table modules.
package sflt_pkg;

    localparam int ADDR_MAX_W = 13;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  slot_index;
        logic [31:0] entry_data;
    } t_in_beat;

    typedef struct packed {
        logic [5:0]  result_slot;
        logic [31:0] read_data;
        logic        slot_occupied;
        logic        table_full;
        logic [6:0]  used_length;
    } t_out_beat;

    typedef struct packed {
        logic                  rd;
        logic [ADDR_MAX_W-1:0] rd_addr;
        logic [ADDR_MAX_W-1:0] wr_addr;
        logic                  occ_we;
        logic                  occ_wd;
        logic                  data_we;
        logic [31:0]           data_wd;
    } t_mem_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_ADD_RD,
        ST_ADD_CHK,
        ST_ACC_CHK,
        ST_TRIM_RD,
        ST_TRIM_CHK,
        ST_DONE
    } t_seq_state;

endpackage

// ===== design/slot_free_list_table.sv =====
// Top level of the slot free list table: sequencer, slot memories and result register.
// Slot table with free-slot reuse. After reset the block clears every slot of the occupancy
// memory and holds o_in_stall high meanwhile. It then works on one beat at a time; each
// step of the sequencer does at most one access to the occupancy/data memories, which have
// one write and one registered read port, so each read state is followed by a check state
// that uses the read data. A read or remove inside the length reads and checks its slot;
// one beyond the length or an undefined operation goes straight to the result. Removing the
// top slot then trims the length past the free slots below it, stopping at an occupied
// slot. An add scans the slots from the bottom for a free one, and appends or is refused
// when none inside the length is free. The next beat is accepted only once the result has
// moved out and the sequencer is idle again. A finished result sits in an output register,
// so a stalled output only holds the block once the next result is ready.
module slot_free_list_table #(
    parameter int SLOT_COUNT = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sflt_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sflt_pkg::t_out_beat o_out_beat
);

    sflt_pkg::t_mem_cmd    mem_cmd;
    sflt_pkg::t_out_beat   res;
    logic                  occ_q;
    logic [DATA_WIDTH-1:0] data_q;
    logic                  busy;
    logic                  res_valid;
    logic                  res_take;

    logic                  r_out_valid;
    sflt_pkg::t_out_beat   r_out_beat;

    sflt_seq #(
        .SLOT_COUNT (SLOT_COUNT),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_beat   (i_in_beat),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res),
        .o_cmd       (mem_cmd),
        .i_occ_q     (occ_q),
        .i_data_q    (data_q)
    );

    sflt_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk    (i_clk),
        .i_cmd    (mem_cmd),
        .o_occ_q  (occ_q),
        .o_data_q (data_q)
    );

    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) r_out_beat <= res;
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

`include "slot_free_list_table_assert.svh"

    `SFLT_ASSERT_NEXT(a_accept_then_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        o_in_stall, "input beat accepted but block not busy next cycle")
    `SFLT_ASSERT_NOW(a_full_refused, i_clk, i_rst_n, o_out_valid && o_out_beat.table_full,
        !o_out_beat.slot_occupied && o_out_beat.result_slot == 6'd0,
        "refused add reports a placed slot")
    `SFLT_ASSERT_NOW(a_data_needs_occ, i_clk, i_rst_n,
        o_out_valid && o_out_beat.read_data != 32'd0, o_out_beat.slot_occupied,
        "nonzero read data from a free slot")
    `SFLT_ASSERT_NOW(a_length_bound, i_clk, i_rst_n, o_out_valid,
        32'(o_out_beat.used_length) <= 32'(SLOT_COUNT), "length beyond slot count")

endmodule

// ===== design/sflt_mem.sv =====
// Occupancy and data memories of the slot table, one write and one registered read port.
module sflt_mem #(
    parameter int SLOT_COUNT = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  sflt_pkg::t_mem_cmd    i_cmd,
    output logic                  o_occ_q,
    output logic [DATA_WIDTH-1:0] o_data_q
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic                  r_occ_mem  [SLOT_COUNT];
    logic [DATA_WIDTH-1:0] r_data_mem [SLOT_COUNT];
    logic                  r_occ_q;
    logic [DATA_WIDTH-1:0] r_data_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.occ_we) begin
            r_occ_mem[i_cmd.wr_addr[SW-1:0]] <= i_cmd.occ_wd;
        end
        if (i_cmd.data_we) begin
            r_data_mem[i_cmd.wr_addr[SW-1:0]] <= DATA_WIDTH'(i_cmd.data_wd);
        end
        if (i_cmd.rd) begin
            r_occ_q  <= r_occ_mem[i_cmd.rd_addr[SW-1:0]];
            r_data_q <= r_data_mem[i_cmd.rd_addr[SW-1:0]];
        end
    end

    assign o_occ_q  = r_occ_q;
    assign o_data_q = r_data_q;

endmodule

// ===== design/sflt_seq.sv =====
// Sequencer that scans, updates and trims the slot table one slot per step.
module sflt_seq #(
    parameter int SLOT_COUNT = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  sflt_pkg::t_in_beat    i_in_beat,
    output logic                  o_busy,
    output logic                  o_res_valid,
    input  logic                  i_res_take,
    output sflt_pkg::t_out_beat   o_res,
    output sflt_pkg::t_mem_cmd    o_cmd,
    input  logic                  i_occ_q,
    input  logic [DATA_WIDTH-1:0] i_data_q
);

    localparam int LW = $clog2(SLOT_COUNT + 1);
    localparam int CW = (LW > 7) ? LW : 7;
    localparam int AW = sflt_pkg::ADDR_MAX_W;

    sflt_pkg::t_seq_state r_state, n_state;

    logic [LW-1:0]         r_hw;
    logic [LW-1:0]         r_ptr;
    logic [LW-1:0]         r_slot;
    logic [1:0]            r_op;
    logic [5:0]            r_idx;
    logic [31:0]           r_wdata;
    logic                  r_occ;
    logic                  r_full;
    logic [DATA_WIDTH-1:0] r_rdata;

    logic ptr_at_hw;
    logic hw_full;
    logic hw_zero;
    logic in_range;
    logic is_last;
    logic is_access;

    assign ptr_at_hw = (r_ptr == r_hw);
    assign hw_full   = (r_hw == LW'(SLOT_COUNT));
    assign hw_zero   = (r_hw == '0);
    assign in_range  = (CW'(r_idx) < CW'(r_hw));
    assign is_last   = ((CW'(r_idx) + CW'(1)) == CW'(r_hw));
    assign is_access = (r_op == sflt_pkg::OP_REMOVE) || (r_op == sflt_pkg::OP_READ);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sflt_pkg::ST_CLEAR: begin
                if (r_ptr == LW'(SLOT_COUNT - 1)) n_state = sflt_pkg::ST_IDLE;
            end
            sflt_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = sflt_pkg::ST_START;
            end
            sflt_pkg::ST_START: begin
                case (r_op) inside
                    sflt_pkg::OP_ADD: n_state = sflt_pkg::ST_ADD_RD;
                    sflt_pkg::OP_REMOVE, sflt_pkg::OP_READ: begin
                        n_state = in_range ? sflt_pkg::ST_ACC_CHK : sflt_pkg::ST_DONE;
                    end
                    default: n_state = sflt_pkg::ST_DONE;
                endcase
            end
            sflt_pkg::ST_ADD_RD: begin
                n_state = ptr_at_hw ? sflt_pkg::ST_DONE : sflt_pkg::ST_ADD_CHK;
            end
            sflt_pkg::ST_ADD_CHK: begin
                n_state = i_occ_q ? sflt_pkg::ST_ADD_RD : sflt_pkg::ST_DONE;
            end
            sflt_pkg::ST_ACC_CHK: begin
                if (r_op == sflt_pkg::OP_REMOVE && i_occ_q && is_last) begin
                    n_state = sflt_pkg::ST_TRIM_RD;
                end else begin
                    n_state = sflt_pkg::ST_DONE;
                end
            end
            sflt_pkg::ST_TRIM_RD: begin
                n_state = hw_zero ? sflt_pkg::ST_DONE : sflt_pkg::ST_TRIM_CHK;
            end
            sflt_pkg::ST_TRIM_CHK: begin
                n_state = i_occ_q ? sflt_pkg::ST_DONE : sflt_pkg::ST_TRIM_RD;
            end
            sflt_pkg::ST_DONE: begin
                if (i_res_take) n_state = sflt_pkg::ST_IDLE;
            end
            default: n_state = sflt_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.data_wd = r_wdata;
        o_busy        = (r_state != sflt_pkg::ST_IDLE);
        o_res_valid   = (r_state == sflt_pkg::ST_DONE);
        unique case (r_state)
            sflt_pkg::ST_CLEAR: begin
                o_cmd.occ_we  = 1'b1;
                o_cmd.wr_addr = AW'(r_ptr);
            end
            sflt_pkg::ST_START: begin
                if (is_access && in_range) begin
                    o_cmd.rd      = 1'b1;
                    o_cmd.rd_addr = AW'(r_idx);
                end
            end
            sflt_pkg::ST_ADD_RD: begin
                if (!ptr_at_hw) begin
                    o_cmd.rd      = 1'b1;
                    o_cmd.rd_addr = AW'(r_ptr);
                end else if (!hw_full) begin
                    o_cmd.occ_we  = 1'b1;
                    o_cmd.occ_wd  = 1'b1;
                    o_cmd.data_we = 1'b1;
                    o_cmd.wr_addr = AW'(r_hw);
                end
            end
            sflt_pkg::ST_ADD_CHK: begin
                if (!i_occ_q) begin
                    o_cmd.occ_we  = 1'b1;
                    o_cmd.occ_wd  = 1'b1;
                    o_cmd.data_we = 1'b1;
                    o_cmd.wr_addr = AW'(r_ptr);
                end
            end
            sflt_pkg::ST_ACC_CHK: begin
                if (r_op == sflt_pkg::OP_REMOVE && i_occ_q) begin
                    o_cmd.occ_we  = 1'b1;
                    o_cmd.wr_addr = AW'(r_idx);
                end
            end
            sflt_pkg::ST_TRIM_RD: begin
                if (!hw_zero) begin
                    o_cmd.rd      = 1'b1;
                    o_cmd.rd_addr = AW'(r_hw - LW'(1));
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sflt_pkg::ST_CLEAR;
            r_hw    <= '0;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                sflt_pkg::ST_CLEAR: begin
                    r_ptr <= r_ptr + LW'(1);
                end
                sflt_pkg::ST_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_in_beat.operation;
                        r_idx   <= i_in_beat.slot_index;
                        r_wdata <= i_in_beat.entry_data;
                        r_ptr   <= '0;
                        r_slot  <= '0;
                        r_occ   <= 1'b0;
                        r_full  <= 1'b0;
                        r_rdata <= '0;
                    end
                end
                sflt_pkg::ST_ADD_RD: begin
                    if (ptr_at_hw) begin
                        if (!hw_full) begin
                            r_slot <= r_hw;
                            r_hw   <= r_hw + LW'(1);
                            r_occ  <= 1'b1;
                        end else begin
                            r_full <= 1'b1;
                        end
                    end
                end
                sflt_pkg::ST_ADD_CHK: begin
                    if (!i_occ_q) begin
                        r_slot <= r_ptr;
                        r_occ  <= 1'b1;
                    end else begin
                        r_ptr <= r_ptr + LW'(1);
                    end
                end
                sflt_pkg::ST_ACC_CHK: begin
                    if (i_occ_q) begin
                        r_occ <= 1'b1;
                        if (r_op == sflt_pkg::OP_READ) r_rdata <= i_data_q;
                        if (r_op == sflt_pkg::OP_REMOVE && is_last) r_hw <= LW'(r_idx);
                    end
                end
                sflt_pkg::ST_TRIM_CHK: begin
                    if (!i_occ_q) r_hw <= r_hw - LW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_res.result_slot   = (r_op == sflt_pkg::OP_ADD) ? 6'(r_slot) : r_idx;
    assign o_res.read_data     = 32'(r_rdata);
    assign o_res.slot_occupied = r_occ;
    assign o_res.table_full    = r_full;
    assign o_res.used_length   = 7'(r_hw);

endmodule

// ===== tb/slot_free_list_table_tb.sv =====
// Self-checking testbench for the slot free list table: directed, fill/drain, random, backpressure.
`timescale 1ns / 100ps

module slot_free_list_table_tb;

    localparam int SLOTS = 64;
    localparam logic [1:0] OP_UNDEF = 2'd3;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    sflt_pkg::t_in_beat  i_in_beat;
    logic                o_out_valid;
    logic                i_out_stall;
    sflt_pkg::t_out_beat o_out_beat;

    slot_free_list_table #(
        .SLOT_COUNT(SLOTS),
        .DATA_WIDTH(32)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_beat (o_out_beat)
    );

    bit          occ_bits[SLOTS];
    logic [31:0] slot_words[SLOTS];
    bit          ever_written[SLOTS];
    int          tbl_len;
    int          n_used;

    sflt_pkg::t_out_beat pending_results[$];
    sflt_pkg::t_out_beat got_beat;
    sflt_pkg::t_out_beat want_beat;

    int src_idle_pct;
    int dst_stall_pct;
    int hold_left;
    int err_cnt;

    int n_beats, n_add, n_full, n_rm_hit, n_rd_hit, n_undef, peak_len, n_trims;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #15ms;
        $display("TB_ERROR");
        $finish;
    end

    // Result of one operation on the slot table; updates the table copy.
    function automatic sflt_pkg::t_out_beat apply_slot_op(input sflt_pkg::t_in_beat b);
        sflt_pkg::t_out_beat r;
        int        found;
        int        i;
        int        old_len;
        r = '0;
        r.result_slot = b.slot_index;
        n_beats++;
        case (b.operation)
            sflt_pkg::OP_ADD: begin
                n_add++;
                found = -1;
                for (i = 0; i < tbl_len && found < 0; i++) begin
                    if (!occ_bits[i]) found = i;
                end
                if (found < 0 && tbl_len < SLOTS) begin
                    found = tbl_len;
                    tbl_len++;
                end
                if (found >= 0) begin
                    occ_bits[found] = 1'b1;
                    slot_words[found] = b.entry_data;
                    ever_written[found] = 1'b1;
                    n_used++;
                    r.result_slot = 6'(found);
                    r.slot_occupied = 1'b1;
                end else begin
                    n_full++;
                    r.result_slot = '0;
                    r.table_full = 1'b1;
                end
            end
            sflt_pkg::OP_REMOVE: begin
                if (int'(b.slot_index) < tbl_len && occ_bits[b.slot_index]) begin
                    n_rm_hit++;
                    r.slot_occupied = 1'b1;
                    occ_bits[b.slot_index] = 1'b0;
                    n_used--;
                    if (int'(b.slot_index) + 1 == tbl_len) begin
                        old_len = tbl_len;
                        while (tbl_len > 0 && !occ_bits[tbl_len - 1]) tbl_len--;
                        if (old_len - tbl_len > 1) n_trims++;
                    end
                end
            end
            sflt_pkg::OP_READ: begin
                if (int'(b.slot_index) < tbl_len && occ_bits[b.slot_index]) begin
                    n_rd_hit++;
                    r.slot_occupied = 1'b1;
                    r.read_data = slot_words[b.slot_index];
                end
            end
            default: begin
                n_undef++;
            end
        endcase
        if (tbl_len > peak_len) peak_len = tbl_len;
        r.used_length = 7'(tbl_len);
        return r;
    endfunction

    function automatic sflt_pkg::t_in_beat mk_beat(input logic [1:0] op, input int idx,
                                                   input logic [31:0] data);
        sflt_pkg::t_in_beat b;
        b.operation = op;
        b.slot_index = 6'(idx);
        b.entry_data = data;
        return b;
    endfunction

    function automatic sflt_pkg::t_in_beat make_random_beat(input int add_pct);
        sflt_pkg::t_in_beat b;
        int       s;
        int       k;
        b.entry_data = $urandom;
        b.slot_index = 6'($urandom_range(0, SLOTS - 1));
        if (tbl_len > 0 && $urandom_range(0, 99) < 80)
            b.slot_index = 6'($urandom_range(0, tbl_len - 1));
        if ($urandom_range(0, 99) < add_pct) begin
            b.operation = sflt_pkg::OP_ADD;
        end else begin
            s = $urandom_range(0, 99);
            if (s < 4) b.operation = OP_UNDEF;
            else if (s < 52) b.operation = sflt_pkg::OP_REMOVE;
            else b.operation = sflt_pkg::OP_READ;
        end
        // steer reads away from slots whose word was never stored
        if (b.operation == sflt_pkg::OP_READ) begin
            for (k = 0; k < SLOTS && !ever_written[b.slot_index]; k++) b.slot_index++;
            if (!ever_written[b.slot_index]) b.operation = sflt_pkg::OP_REMOVE;
        end
        return b;
    endfunction

    // Entered and left at a falling edge.
    task automatic send_beat(input sflt_pkg::t_in_beat b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(apply_slot_op(b));
        @(negedge i_clk);
    endtask

    task automatic report_field(input string name, input longint unsigned want,
                                input longint unsigned got);
        err_cnt++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_beat = o_out_beat;
            if (pending_results.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result beat 0x%0h, expected none", $time, got_beat);
            end else begin
                want_beat = pending_results.pop_front();
                if (got_beat.result_slot !== want_beat.result_slot)
                    report_field("result_slot", want_beat.result_slot, got_beat.result_slot);
                if (got_beat.read_data !== want_beat.read_data)
                    report_field("read_data", want_beat.read_data, got_beat.read_data);
                if (got_beat.slot_occupied !== want_beat.slot_occupied)
                    report_field("slot_occupied", want_beat.slot_occupied,
                                 got_beat.slot_occupied);
                if (got_beat.table_full !== want_beat.table_full)
                    report_field("table_full", want_beat.table_full, got_beat.table_full);
                if (got_beat.used_length !== want_beat.used_length)
                    report_field("used_length", want_beat.used_length, got_beat.used_length);
            end
        end
    end

    initial begin
        i_out_stall = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < dst_stall_pct);
            end
            @(negedge i_clk);
        end
    end

    task automatic test_directed();
        send_beat(mk_beat(sflt_pkg::OP_ADD, 0, 32'hFFFF_FFFF));
        send_beat(mk_beat(sflt_pkg::OP_ADD, 63, 32'h0000_0000));
        send_beat(mk_beat(sflt_pkg::OP_ADD, 0, 32'h5555_5555));
        send_beat(mk_beat(sflt_pkg::OP_ADD, 0, 32'hAAAA_AAAA));
        send_beat(mk_beat(sflt_pkg::OP_ADD, 0, 32'h1234_5678));
        send_beat(mk_beat(sflt_pkg::OP_READ, 0, 32'h0));
        send_beat(mk_beat(sflt_pkg::OP_READ, 4, 32'hFFFF_FFFF));
        send_beat(mk_beat(sflt_pkg::OP_REMOVE, 1, 32'h0));
        send_beat(mk_beat(sflt_pkg::OP_REMOVE, 1, 32'h0));
        send_beat(mk_beat(sflt_pkg::OP_READ, 1, 32'h0));
        send_beat(mk_beat(sflt_pkg::OP_ADD, 40, 32'hDEAD_BEEF));
        send_beat(mk_beat(sflt_pkg::OP_READ, 1, 32'h0));
        send_beat(mk_beat(sflt_pkg::OP_REMOVE, 2, 32'h0));
        send_beat(mk_beat(sflt_pkg::OP_REMOVE, 3, 32'h0));
        send_beat(mk_beat(sflt_pkg::OP_REMOVE, 4, 32'h0));
        send_beat(mk_beat(sflt_pkg::OP_READ, 3, 32'h0));
        send_beat(mk_beat(sflt_pkg::OP_READ, 4, 32'h0));
        send_beat(mk_beat(sflt_pkg::OP_REMOVE, 63, 32'hFFFF_FFFF));
        send_beat(mk_beat(OP_UNDEF, 63, 32'hFFFF_FFFF));
        send_beat(mk_beat(OP_UNDEF, 0, 32'h0));
        send_beat(mk_beat(sflt_pkg::OP_REMOVE, 0, 32'h0));
        send_beat(mk_beat(sflt_pkg::OP_REMOVE, 1, 32'h0));
        send_beat(mk_beat(sflt_pkg::OP_ADD, 0, 32'h8000_0001));
    endtask

    task automatic test_fill_drain();
        int idx;
        while (n_used < SLOTS) send_beat(make_random_beat(100));
        repeat (3) send_beat(make_random_beat(100));
        repeat (16) send_beat(mk_beat(sflt_pkg::OP_READ, $urandom_range(0, SLOTS - 1),
                                      $urandom));
        // drain in random order; each removal of the top slot trims past freed slots
        while (tbl_len > 0) begin
            idx = $urandom_range(0, tbl_len - 1);
            while (!occ_bits[idx]) idx = (idx + 1) % tbl_len;
            send_beat(mk_beat(sflt_pkg::OP_REMOVE, idx, $urandom));
        end
    endtask

    task automatic test_random(input int count);
        int add_pct;
        add_pct = 50;
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) add_pct = $urandom_range(20, 80);
            send_beat(make_random_beat(add_pct));
        end
    endtask

    task automatic test_backpressure();
        hold_left = 300;
        repeat (40) send_beat(make_random_beat(50));
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_beat  = '0;
        hold_left  = 0;
        err_cnt    = 0;
        src_idle_pct  = 29;
        dst_stall_pct = 59;
        tbl_len = 0;
        n_used  = 0;
        for (int i = 0; i < SLOTS; i++) begin
            occ_bits[i] = 1'b0;
            ever_written[i] = 1'b0;
            slot_words[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(380);
        src_idle_pct  = 59;
        dst_stall_pct = 29;
        test_fill_drain();
        test_random(380);
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        test_random(380);
        test_backpressure();
        test_random(60);

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);

        $display("Covered %0d beats: %0d adds (%0d refused on a full table), %0d removes hit,",
                 n_beats, n_add, n_full, n_rm_hit);
        $display("%0d reads hit, %0d undefined ops, peak length %0d, %0d multi-slot trims.",
                 n_rd_hit, n_undef, peak_len, n_trims);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== slot_free_list_table.f =====
+incdir+design
design/sflt_pkg.sv
design/sflt_mem.sv
design/sflt_seq.sv
design/slot_free_list_table.sv
tb/slot_free_list_table_tb.sv
